// ----- design/atc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg
// Types and constants for the time code to epoch microseconds converter.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int YEAR_W   = 32;
    localparam int DAY_W    = 32;
    localparam int MS_W     = 27;
    localparam int US_W     = 10;
    localparam int OUT_W    = 51;

    // Day count since the epoch fits in 15 bits (at most 25932)
    localparam int DAYS_W   = 15;
    localparam int YOFF_W   = 7;
    localparam int DOFF_W   = 9;
    localparam int CNT_W    = 5;

    localparam logic signed [YEAR_W-1:0] EPOCH_YEAR = 32'sd1970;
    localparam logic signed [YEAR_W-1:0] LAST_YEAR  = 32'sd2040;
    localparam logic [YOFF_W-1:0]        LAST_YOFF  = 7'd70;
    localparam logic signed [DAY_W-1:0]  DAYS_MAX   = 32'sd366;
    localparam logic [DAYS_W-1:0]        DAYS_COMMON = 15'd365;

    localparam logic [MS_W-1:0] MILLIS_MAX = 27'd86399999;
    localparam logic [US_W-1:0] MICROS_MAX = 10'd999;

    // Microseconds per day, and per millisecond
    localparam logic [OUT_W-1:0] US_PER_DAY = 51'd86400000000;
    localparam logic [OUT_W-1:0] US_PER_MS  = 51'd1000;

    localparam logic [CNT_W-1:0] DAY_STEPS = 5'(DAYS_W - 1);
    localparam logic [CNT_W-1:0] MS_STEPS  = 5'(MS_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_DAY,
        ST_MUL_MS,
        ST_DONE
    } atc_state_t;

endpackage

// ----- design/atc_time_code_to_epoch_us_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_time_code_to_epoch_us_core
// Converts a year / day-of-year / millis / micros time code to microseconds
// since 1970-01-01 using bit-serial shift-and-add multiplication.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and the clamps
// are applied as it is taken. The preparation state then forms the day count.
// A single 51-bit shift-and-add accumulator walks the 15 bits of the day
// count and then the 27 bits of the millisecond count, one bit per cycle.
// The result is shown on epoch_micros with done high for one cycle. Busy
// stays high until that cycle is over, so no new transaction is taken
// while a conversion is under way.
// The receiver must take the result in the done cycle; it cannot stall it.
module atc_time_code_to_epoch_us_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [atc_pkg::YEAR_W-1:0] year_word,
    input  logic signed [atc_pkg::DAY_W-1:0]  day_word,
    input  logic [atc_pkg::MS_W-1:0]          millis_of_day,
    input  logic [atc_pkg::US_W-1:0]          micros_part,
    output logic                              done,
    output logic [atc_pkg::OUT_W-1:0]         epoch_micros
);
    import atc_pkg::*;

    atc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MS_W-1:0]     shf_reg, shf_next;
    logic [OUT_W-1:0]    mcand_reg, mcand_next;
    logic [OUT_W-1:0]    acc_reg, acc_next;
    logic [YOFF_W-1:0]   yoff_reg, yoff_next;
    logic [DOFF_W-1:0]   doff_reg, doff_next;
    logic [MS_W-1:0]     ms_reg, ms_next;

    logic                accept;
    logic [DAYS_W-1:0]   days_w;
    logic [5:0]          leaps_w;
    logic [OUT_W-1:0]    acc_add;

    assign accept = start && (state_reg == ST_IDLE);

    // Leap years 1972.. up to year-1; no century exceptions inside the range
    assign leaps_w = 6'(({1'b0, yoff_reg} + 8'd1) >> 2);
    assign days_w  = {8'd0, yoff_reg} * DAYS_COMMON + {9'd0, leaps_w} + {6'd0, doff_reg};

    assign acc_add = shf_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_PREP;
            ST_PREP:    state_next = ST_MUL_DAY;
            ST_MUL_DAY: if (cnt_reg == '0) state_next = ST_MUL_MS;
            ST_MUL_MS:  if (cnt_reg == '0) state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        cnt_next   = cnt_reg;
        shf_next   = shf_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        yoff_next  = yoff_reg;
        doff_next  = doff_reg;
        ms_next    = ms_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (year_word < EPOCH_YEAR)
                        yoff_next = '0;
                    else if (year_word > LAST_YEAR)
                        yoff_next = LAST_YOFF;
                    else
                        yoff_next = YOFF_W'(year_word - EPOCH_YEAR);
                    if (day_word < 32'sd1 || day_word > DAYS_MAX)
                        doff_next = '0;
                    else
                        doff_next = DOFF_W'(day_word - 32'sd1);
                    ms_next  = (millis_of_day > MILLIS_MAX) ? MILLIS_MAX : millis_of_day;
                    acc_next = {41'd0, (micros_part > MICROS_MAX) ? MICROS_MAX : micros_part};
                end
            end
            ST_PREP:
            begin
                shf_next   = {12'd0, days_w};
                mcand_next = US_PER_DAY;
                cnt_next   = DAY_STEPS;
            end
            ST_MUL_DAY:
            begin
                acc_next = acc_add;
                if (cnt_reg == '0)
                begin
                    shf_next   = ms_reg;
                    mcand_next = US_PER_MS;
                    cnt_next   = MS_STEPS;
                end
                else
                begin
                    shf_next   = shf_reg >> 1;
                    mcand_next = mcand_reg << 1;
                    cnt_next   = cnt_reg - 5'd1;
                end
            end
            ST_MUL_MS:
            begin
                acc_next   = acc_add;
                shf_next   = shf_reg >> 1;
                mcand_next = mcand_reg << 1;
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - 5'd1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        done         = (state_reg == ST_DONE);
        epoch_micros = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shf_reg   <= shf_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        yoff_reg  <= yoff_next;
        doff_reg  <= doff_next;
        ms_reg    <= ms_next;
    end

`ifndef SYNTH
    a_start_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_PREP))
        else $error("accepted transaction did not enter preparation");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not single or block still busy");

    a_done_after_ms: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_MUL_MS && $past(cnt_reg) == '0))
        else $error("result strobe without completed millisecond pass");

    a_yoff_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> (yoff_reg <= LAST_YOFF))
        else $error("year offset outside clamp range");
`endif

endmodule
